[rtl/core/assert_macros.svh]
// Assertion macros shared by the list engine RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed");

`endif

[rtl/core/ple_pkg.sv]
// Shared types for the positional list engine.
// Holds operation and status codes and the controller/datapath structs.
package ple_pkg;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_GET     = 2'd2,
    OP_REPLACE = 2'd3
  } ple_op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } ple_status_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture the input word
    logic rd_shift;  // read the neighbor of the shift index
    logic rd_pos;    // read the addressed entry
    logic capture;   // latch read data as the result value
    logic wr_shift;  // write read data at the shift index and step it
    logic wr_fin;    // write the input value at the position
    logic commit;    // update count and load the result register
  } ple_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    ple_op_t op;
    logic    err;
    logic    shift_more;
    logic    out_free;
  } ple_stat_t;

endpackage

[rtl/core/positional_list_engine_unit.sv]
// Positional list engine: insert, delete, get and replace on a dense list.
// Errors go straight to the result; insert and delete move entries one at a time,
// each moved entry costing a read and a write on the registered-read RAM.
// One word in flight; the next is taken once its result is loaded and the
// controller is back in idle.
// Synchronous reset empties the list; RAM contents are not cleared.
`include "assert_macros.svh"

module positional_list_engine_unit #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [4:0]  in_position,
  input  logic [31:0] in_item_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_value,
  output logic [4:0]  out_entry_count,
  output logic        out_is_empty,
  output logic        out_is_full
);
  import ple_pkg::*;

  ple_cmd_t  cmd;
  ple_stat_t stat;

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ple_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_item_value   (in_item_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

  // Busy right after a word is taken
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // Errors return a zero value
  `ASSERT_SAME(a_err_zero_value, clk, rst_n, out_valid && (out_status != ST_DONE), out_read_value == '0)
  // A full refusal leaves the list full
  `ASSERT_SAME(a_full_status, clk, rst_n, out_valid && (out_status == ST_FULL), out_is_full)

endmodule

[rtl/core/ple_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ple_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/ple_ctrl.sv]
// Controller state machine for the positional list engine.
// Depends on ple_pkg; drives commands to ple_dp and reads its status.
module ple_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ple_pkg::ple_stat_t stat,
  output ple_pkg::ple_cmd_t  cmd
);
  import ple_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SH_RD,
    S_SH_WR,
    S_GRD,
    S_GCAP,
    S_WR_FIN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Decode commands and next state
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.err) begin
          state_nxt = S_DONE;
        end else begin
          unique case (stat.op)
            OP_INSERT:              state_nxt = S_SH_RD;
            OP_DELETE, OP_GET:      state_nxt = S_GRD;
            OP_REPLACE:             state_nxt = S_WR_FIN;
            default:                state_nxt = S_DONE;
          endcase
        end
      end
      S_SH_RD: begin
        if (stat.shift_more) begin
          cmd.rd_shift = 1'b1;
          state_nxt    = S_SH_WR;
        end else if (stat.op == OP_INSERT) begin
          state_nxt = S_WR_FIN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = S_SH_RD;
      end
      S_GRD: begin
        cmd.rd_pos = 1'b1;
        state_nxt  = S_GCAP;
      end
      S_GCAP: begin
        cmd.capture = 1'b1;
        state_nxt   = (stat.op == OP_DELETE) ? S_SH_RD : S_DONE;
      end
      S_WR_FIN: begin
        cmd.wr_fin = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

[rtl/core/ple_dp.sv]
// Datapath for the positional list engine: operand, count and result
// registers plus the entry RAM. Depends on ple_pkg and ple_ram.
module ple_dp #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_operation,
  input  logic [4:0]         in_position,
  input  logic [31:0]        in_item_value,
  input  ple_pkg::ple_cmd_t  cmd,
  output ple_pkg::ple_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [31:0]        out_read_value,
  output logic [4:0]         out_entry_count,
  output logic               out_is_empty,
  output logic               out_is_full
);
  import ple_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 5) ? CW : 5;
  localparam int AW = $clog2(DEPTH);

  ple_op_t         op_r;
  logic [PW-1:0]   pos_r;
  logic [31:0]     val_r;
  logic [PW-1:0]   idx_r;
  logic [31:0]     rd_r;
  logic [CW-1:0]   count_r;
  logic            out_valid_r;
  logic [1:0]      out_status_r;
  logic [31:0]     out_read_value_r;
  logic [4:0]      out_entry_count_r;
  logic            out_is_empty_r;
  logic            out_is_full_r;

  logic [PW-1:0]   count_e;
  logic [PW-1:0]   idx_up;
  logic [PW-1:0]   idx_dn;
  logic            is_full_now;
  ple_status_t     status_c;
  logic [CW-1:0]   count_new;
  logic [PW-1:0]   count_new_e;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [31:0]     ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [31:0]     ram_rdata;

  assign count_e     = PW'(count_r);
  assign idx_up      = idx_r + PW'(1);
  assign idx_dn      = idx_r - PW'(1);
  assign is_full_now = (count_r == CW'(DEPTH));

  // Classify the held word: position check first, then full
  always_comb begin
    status_c = ST_DONE;
    if (op_r == OP_INSERT) begin
      if (pos_r > count_e) begin
        status_c = ST_RANGE;
      end else if (is_full_now) begin
        status_c = ST_FULL;
      end
    end else if (pos_r >= count_e) begin
      status_c = ST_RANGE;
    end
  end

  assign stat.op         = op_r;
  assign stat.err        = (status_c != ST_DONE);
  assign stat.shift_more = (op_r == OP_INSERT) ? (idx_r != pos_r) : (idx_up < count_e);
  assign stat.out_free   = !out_valid_r || !out_stall;

  // Count after the operation
  always_comb begin
    count_new = count_r;
    if (status_c == ST_DONE) begin
      if (op_r == OP_INSERT) begin
        count_new = count_r + CW'(1);
      end else if (op_r == OP_DELETE) begin
        count_new = count_r - CW'(1);
      end
    end
  end
  assign count_new_e = PW'(count_new);

  // Entry RAM ports
  assign ram_we    = cmd.wr_shift || cmd.wr_fin;
  assign ram_waddr = cmd.wr_fin ? pos_r[AW-1:0] : idx_r[AW-1:0];
  assign ram_wdata = cmd.wr_fin ? val_r : ram_rdata;
  always_comb begin
    if (cmd.rd_pos) begin
      ram_raddr = pos_r[AW-1:0];
    end else if (cmd.rd_shift) begin
      ram_raddr = (op_r == OP_INSERT) ? idx_dn[AW-1:0] : idx_up[AW-1:0];
    end else begin
      ram_raddr = pos_r[AW-1:0];
    end
  end

  ple_ram #(
    .W(32),
    .D(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Hold operands, shift index and read result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= ple_op_t'(in_operation);
      pos_r <= PW'(in_position);
      val_r <= in_item_value;
      idx_r <= (ple_op_t'(in_operation) == OP_INSERT) ? count_e : PW'(in_position);
      rd_r  <= '0;
    end else begin
      if (cmd.wr_shift) begin
        idx_r <= (op_r == OP_INSERT) ? idx_dn : idx_up;
      end
      if (cmd.capture) begin
        rd_r <= ram_rdata;
      end
    end
  end

  // Advance the entry count on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_new;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r      <= status_c;
      out_read_value_r  <= rd_r;
      out_entry_count_r <= count_new_e[4:0];
      out_is_empty_r    <= (count_new == '0);
      out_is_full_r     <= (count_new == CW'(DEPTH));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_entry_count = out_entry_count_r;
  assign out_is_empty    = out_is_empty_r;
  assign out_is_full     = out_is_full_r;

endmodule
